/* design/kck_pkg.sv */
// Shared types, constants and the Morse pattern table for the character keyer.
`default_nettype none
package kck_pkg;

    // Field widths
    localparam int CHAR_W = 8;
    localparam int DOT_W  = 12;
    localparam int DUR_W  = 15;
    localparam int LEN_W  = 3;
    localparam int PAT_W  = 5;
    localparam int IDX_W  = 6;

    // Reset value of the unit length in ms
    localparam logic [DOT_W-1:0] DOT_TIME_RESET = 12'd300;

    // Default depth of the queue between front and back
    localparam int FIFO_DEPTH = 2;

    // ASCII landmarks
    localparam logic [CHAR_W-1:0] ASCII_LC_A  = 8'h61;
    localparam logic [CHAR_W-1:0] ASCII_LC_Z  = 8'h7A;
    localparam logic [CHAR_W-1:0] ASCII_UC_A  = 8'h41;
    localparam logic [CHAR_W-1:0] ASCII_UC_Z  = 8'h5A;
    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] ASCII_CASE  = 8'h20;
    localparam logic [IDX_W-1:0]  DIGIT_BASE  = 6'd26;

    // Pattern of one character: element count and dash mask (bit 0 is sent first)
    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [PAT_W-1:0] pat;
    } t_code;

    // Classified character handed from front to back
    typedef struct packed {
        logic             is_word_gap;
        logic [LEN_W-1:0] len;
        logic [PAT_W-1:0] pat;
    } t_entry;

    // Pattern table: A-Z at 0..25, 0-9 at 26..35; a set bit is a dash
    function automatic t_code kck_rom(input logic [IDX_W-1:0] idx);
        t_code c;
        c = '0;
        case (idx)
            6'd0:  c = '{len: 3'd2, pat: 5'b00010}; // A
            6'd1:  c = '{len: 3'd4, pat: 5'b00001}; // B
            6'd2:  c = '{len: 3'd4, pat: 5'b00101}; // C
            6'd3:  c = '{len: 3'd3, pat: 5'b00001}; // D
            6'd4:  c = '{len: 3'd1, pat: 5'b00000}; // E
            6'd5:  c = '{len: 3'd4, pat: 5'b00100}; // F
            6'd6:  c = '{len: 3'd3, pat: 5'b00011}; // G
            6'd7:  c = '{len: 3'd4, pat: 5'b00000}; // H
            6'd8:  c = '{len: 3'd2, pat: 5'b00000}; // I
            6'd9:  c = '{len: 3'd4, pat: 5'b01110}; // J
            6'd10: c = '{len: 3'd3, pat: 5'b00101}; // K
            6'd11: c = '{len: 3'd4, pat: 5'b00010}; // L
            6'd12: c = '{len: 3'd2, pat: 5'b00011}; // M
            6'd13: c = '{len: 3'd2, pat: 5'b00001}; // N
            6'd14: c = '{len: 3'd3, pat: 5'b00111}; // O
            6'd15: c = '{len: 3'd4, pat: 5'b00110}; // P
            6'd16: c = '{len: 3'd4, pat: 5'b01011}; // Q
            6'd17: c = '{len: 3'd3, pat: 5'b00010}; // R
            6'd18: c = '{len: 3'd3, pat: 5'b00000}; // S
            6'd19: c = '{len: 3'd1, pat: 5'b00001}; // T
            6'd20: c = '{len: 3'd3, pat: 5'b00100}; // U
            6'd21: c = '{len: 3'd4, pat: 5'b01000}; // V
            6'd22: c = '{len: 3'd3, pat: 5'b00110}; // W
            6'd23: c = '{len: 3'd4, pat: 5'b01001}; // X
            6'd24: c = '{len: 3'd4, pat: 5'b01101}; // Y
            6'd25: c = '{len: 3'd4, pat: 5'b00011}; // Z
            6'd26: c = '{len: 3'd5, pat: 5'b11111}; // 0
            6'd27: c = '{len: 3'd5, pat: 5'b11110}; // 1
            6'd28: c = '{len: 3'd5, pat: 5'b11100}; // 2
            6'd29: c = '{len: 3'd5, pat: 5'b11000}; // 3
            6'd30: c = '{len: 3'd5, pat: 5'b10000}; // 4
            6'd31: c = '{len: 3'd5, pat: 5'b00000}; // 5
            6'd32: c = '{len: 3'd5, pat: 5'b00001}; // 6
            6'd33: c = '{len: 3'd5, pat: 5'b00011}; // 7
            6'd34: c = '{len: 3'd5, pat: 5'b00111}; // 8
            6'd35: c = '{len: 3'd5, pat: 5'b01111}; // 9
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

/* design/kck_front.sv */
// Front end: accepts characters, folds case and looks up the Morse pattern.
`default_nettype none
module kck_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [kck_pkg::CHAR_W-1:0]    i_character,
    input  wire logic                          i_fifo_full,
    output logic                               o_push,
    output kck_pkg::t_entry                    o_entry
);

    logic [kck_pkg::CHAR_W-1:0] upper;
    logic                       is_letter;
    logic                       is_digit;
    logic [kck_pkg::IDX_W-1:0]  rom_idx;
    kck_pkg::t_code             code;
    logic                       r_seen;

    // Fold lower case to upper case
    always_comb begin
        upper = i_character;
        if (i_character >= kck_pkg::ASCII_LC_A && i_character <= kck_pkg::ASCII_LC_Z) begin
            upper = i_character - kck_pkg::ASCII_CASE;
        end
    end

    // Classify and index the pattern table
    always_comb begin
        is_letter = (upper >= kck_pkg::ASCII_UC_A) && (upper <= kck_pkg::ASCII_UC_Z);
        is_digit  = (upper >= kck_pkg::ASCII_ZERO) && (upper <= kck_pkg::ASCII_NINE);
        if (is_letter) begin
            rom_idx = kck_pkg::IDX_W'(upper - kck_pkg::ASCII_UC_A);
        end else begin
            rom_idx = kck_pkg::IDX_W'(upper - kck_pkg::ASCII_ZERO) + kck_pkg::DIGIT_BASE;
        end
        code = kck_pkg::kck_rom(rom_idx);
    end

    // Hold off input while the queue is full or until the block is out of reset
    assign o_ready = !i_fifo_full && r_seen;
    assign o_push  = i_valid && o_ready;

    always_comb begin
        o_entry.is_word_gap = !(is_letter || is_digit);
        o_entry.len         = code.len;
        o_entry.pat         = code.pat;
    end

    // Come out of reset before taking characters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else begin
            r_seen <= 1'b1;
        end
    end

endmodule
`default_nettype wire

/* design/kck_fifo.sv */
// Small queue of classified characters between front and back.
`default_nettype none
module kck_fifo #(
    parameter int DEPTH = kck_pkg::FIFO_DEPTH
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire kck_pkg::t_entry i_entry,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_valid,
    output kck_pkg::t_entry      o_entry
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    kck_pkg::t_entry r_mem [DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CW-1:0]   r_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Store pushed entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

/* design/kck_back.sv */
// Back end: steps through the elements of a character and emits one segment per cycle while the output is ready.
`default_nettype none
module kck_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [kck_pkg::DOT_W-1:0]    i_cfg_data,
    input  wire logic                         i_fifo_valid,
    input  wire kck_pkg::t_entry              i_entry,
    output logic                              o_pop,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic                              o_led_level,
    output logic [kck_pkg::DUR_W-1:0]         o_duration_ms,
    output logic                              o_last_segment
);

    typedef enum logic [1:0] {
        t_units_one,
        t_units_three,
        t_units_seven
    } t_units;

    logic [kck_pkg::DOT_W-1:0] r_dot;
    logic                      r_busy;
    kck_pkg::t_entry           r_ent;
    logic [kck_pkg::LEN_W-1:0] r_elem;
    logic                      r_gap;
    logic                      r_valid;
    logic                      r_level;
    logic [kck_pkg::DUR_W-1:0] r_dur;
    logic                      r_last;

    kck_pkg::t_entry           cur;
    logic [kck_pkg::LEN_W-1:0] elem;
    logic                      gap;
    logic                      avail;
    logic                      advance;
    logic [7:0]                pat_ext;
    logic                      n_level;
    logic                      n_last;
    t_units                    units;
    logic [kck_pkg::DUR_W-1:0] dot15;
    logic [kck_pkg::DUR_W-1:0] n_dur;

    // Work on the held character, or start on the queue head
    always_comb begin
        cur     = r_busy ? r_ent : i_entry;
        elem    = r_busy ? r_elem : '0;
        gap     = r_busy ? r_gap : 1'b0;
        avail   = r_busy || i_fifo_valid;
        advance = avail && (!r_valid || i_ready);
        pat_ext = {{(8 - kck_pkg::PAT_W){1'b0}}, cur.pat};
    end

    assign o_pop = advance && !r_busy;

    // Pick the segment for this step
    always_comb begin
        if (cur.is_word_gap) begin
            n_level = 1'b1;
            units   = t_units_seven;
            n_last  = 1'b1;
        end else if (elem == cur.len) begin
            n_level = 1'b1;
            units   = t_units_three;
            n_last  = 1'b1;
        end else if (gap) begin
            n_level = 1'b1;
            units   = t_units_one;
            n_last  = 1'b0;
        end else begin
            n_level = 1'b0;
            units   = pat_ext[elem] ? t_units_three : t_units_one;
            n_last  = 1'b0;
        end
    end

    // Scale the unit count by the dot time
    always_comb begin
        dot15 = kck_pkg::DUR_W'(r_dot);
        case (units)
            t_units_one:   n_dur = dot15;
            t_units_three: n_dur = dot15 + (dot15 << 1);
            t_units_seven: n_dur = (dot15 << 3) - dot15;
            default:       n_dur = dot15;
        endcase
    end

    // Hold the unit length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot <= kck_pkg::DOT_TIME_RESET;
        end else if (i_cfg_we) begin
            r_dot <= i_cfg_data;
        end
    end

    // Advance the element sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_elem <= '0;
            r_gap  <= 1'b0;
        end else if (advance) begin
            if (n_last) begin
                r_busy <= 1'b0;
                r_elem <= '0;
                r_gap  <= 1'b0;
            end else begin
                r_busy <= 1'b1;
                r_gap  <= !gap;
                r_elem <= gap ? elem + 1'b1 : elem;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && !r_busy) begin
            r_ent <= i_entry;
        end
    end

    // Output register: load a new segment or drop the taken one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (advance) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_level <= n_level;
            r_dur   <= n_dur;
            r_last  <= n_last;
        end
    end

    assign o_valid        = r_valid;
    assign o_led_level    = r_level;
    assign o_duration_ms  = r_dur;
    assign o_last_segment = r_last;

endmodule
`default_nettype wire

/* design/morse_char_keyer.sv */
// Top level of the Morse character keyer: front end, queue and segment sequencer.
// Each accepted character turns into a run of key segments, one segment per
// clock when the output side is ready: a single word gap for a character with
// no pattern, or for a letter or digit of n elements 2n+1 segments
// (a mark and an element gap per element, then a letter gap marked last),
// at most 11 segments for a digit. The front end and the queue keep taking
// characters while the back end works, as long as the queue has room, so the
// first segment of a queued character directly follows the last of the one
// before it. The unit length is written through the configuration port
// (reset 300 ms); the user must write it only while the keyer is idle, which
// the block itself does not enforce. Durations are 1, 3 or 7 units times that length.
`default_nettype none
module morse_char_keyer #(
    parameter int FIFO_DEPTH = kck_pkg::FIFO_DEPTH
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [kck_pkg::DOT_W-1:0]    i_cfg_data,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [kck_pkg::CHAR_W-1:0]   i_character,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic                              o_led_level,
    output logic [kck_pkg::DUR_W-1:0]         o_duration_ms,
    output logic                              o_last_segment
);

    logic            fifo_full;
    logic            push;
    kck_pkg::t_entry push_entry;
    logic            pop;
    logic            fifo_valid;
    kck_pkg::t_entry head_entry;

    // Accept and classify characters
    kck_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_character (i_character),
        .i_fifo_full (fifo_full),
        .o_push      (push),
        .o_entry     (push_entry)
    );

    // Decouple front and back
    kck_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (fifo_full),
        .i_pop   (pop),
        .o_valid (fifo_valid),
        .o_entry (head_entry)
    );

    // Emit segments
    kck_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_fifo_valid   (fifo_valid),
        .i_entry        (head_entry),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_led_level    (o_led_level),
        .o_duration_ms  (o_duration_ms),
        .o_last_segment (o_last_segment)
    );

endmodule
`default_nettype wire
